FILE: hw/rtl/ptm_pkg.sv
// Shared types, constants and gray-level functions of the monochrome threshold packer.
package ptm_pkg;

  // Palette geometry and field widths.
  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int COLOR_W           = 24;
  localparam int IDX_W             = 8;
  localparam int CFG_ADDR_W        = 3;
  localparam int CFG_DATA_W        = 32;

  // Pixel formats held in the format register.
  typedef enum logic [1:0] {
    FMT_IDX4   = 2'd0,
    FMT_IDX8   = 2'd1,
    FMT_RGB565 = 2'd2,
    FMT_COLOR  = 2'd3
  } pixel_fmt_t;

  localparam pixel_fmt_t FMT_RESET = FMT_COLOR;

  // Item commands.
  localparam logic CMD_PAL_WRITE = 1'b0;
  localparam logic CMD_PIXEL     = 1'b1;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_PIXEL_FORMAT = 1'b0;

  // Gray level at or above which a pixel is white.
  localparam logic [7:0] WHITE_LEVEL = 8'd128;

  // Item held in the stage that waits for the palette read.
  typedef struct packed {
    logic                    cmd;
    pixel_fmt_t              fmt;
    logic [COLOR_W-1:0]      pixel_value;
    logic                    row_end;
    logic                    idx_oob;
  } s1_item_t;

  // Gray of a three-byte color: (c0 + 2*c1 + c2) / 4.
  function automatic logic [7:0] gray_of_color(input logic [COLOR_W-1:0] color);
    logic [9:0] sum;
    sum = 10'(color[7:0]) + {1'b0, color[15:8], 1'b0} + 10'(color[23:16]);
    return sum[9:2];
  endfunction

  // Gray of an RGB565 word: five-bit fields placed as in the masks 0xf8, 0x1f0 and 0xf8.
  function automatic logic [7:0] gray_of_rgb565(input logic [15:0] word);
    logic [9:0] sum;
    sum = 10'({word[15:11], 3'b000}) + 10'({word[6:2], 4'b0000})
        + 10'({word[4:0], 3'b000});
    return sum[9:2];
  endfunction

endpackage

FILE: hw/rtl/ptm_if.sv
// Valid/ready channel interfaces for pixel items and packed-byte items.
interface ptm_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [23:0] pixel_value;
  logic        row_end;
  logic [7:0]  palette_index;
  logic [23:0] palette_color;

  modport source (output valid, cmd, pixel_value, row_end, palette_index, palette_color,
                  input ready);
  modport sink (input valid, cmd, pixel_value, row_end, palette_index, palette_color,
                output ready);
endinterface

interface ptm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       row_last;

  modport source (output valid, packed_byte, row_last, input ready);
  modport sink (input valid, packed_byte, row_last, output ready);
endinterface

FILE: hw/rtl/ptm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ptm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/ptm_cfg.sv
// APB-style register block holding the pixel format.
module ptm_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ptm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ptm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ptm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output ptm_pkg::pixel_fmt_t            pixel_format
);
  import ptm_pkg::*;

  pixel_fmt_t pixel_format_r;
  pixel_fmt_t pixel_format_nxt;
  logic       wr_en;
  logic       reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign wr_en     = psel && penable && pwrite && pready;

  // Only the format register exists; writes elsewhere are dropped.
  always_comb begin
    pixel_format_nxt = pixel_format_r;
    if (wr_en && (reg_index == REG_PIXEL_FORMAT)) begin
      pixel_format_nxt = pixel_fmt_t'(pwdata[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r <= FMT_RESET;
    end else begin
      pixel_format_r <= pixel_format_nxt;
    end
  end

  // Read-back of the register.
  always_comb begin
    prdata = '0;
    if (reg_index == REG_PIXEL_FORMAT) begin
      prdata = {{(CFG_DATA_W-2){1'b0}}, pixel_format_r};
    end
  end

  assign pixel_format = pixel_format_r;

endmodule

FILE: hw/rtl/ptm_pack.sv
// Gray conversion, threshold, bit packing and the output register.
module ptm_pack (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_valid,
  input  ptm_pkg::s1_item_t             s1_item,
  input  logic [ptm_pkg::COLOR_W-1:0]   pal_color,
  output logic                          s1_advance,
  ptm_out_if.source                     out_ch
);
  import ptm_pkg::*;

  logic [7:0] bit_shifter_r, bit_shifter_nxt;
  logic [2:0] bit_count_r, bit_count_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic [7:0] gray;
  logic       white_bit;
  logic [7:0] shift_full;
  logic [3:0] count_inc;
  logic [3:0] pad;
  logic       is_pixel;
  logic       emit;
  logic       out_free;

  // Gray level of the pixel by format.
  always_comb begin
    case (s1_item.fmt)
      FMT_RGB565: gray = gray_of_rgb565(s1_item.pixel_value[15:0]);
      FMT_COLOR:  gray = gray_of_color(s1_item.pixel_value);
      default:    gray = s1_item.idx_oob ? 8'd0 : gray_of_color(pal_color);
    endcase
  end

  assign white_bit  = (gray >= WHITE_LEVEL);
  assign shift_full = {bit_shifter_r[6:0], white_bit};
  assign count_inc  = {1'b0, bit_count_r} + 4'd1;
  assign pad        = 4'd8 - count_inc;
  assign is_pixel   = s1_valid && (s1_item.cmd == CMD_PIXEL);
  assign emit       = is_pixel && ((bit_count_r == 3'd7) || s1_item.row_end);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign s1_advance = s1_valid && (!emit || out_free);

  // Packing state and output register.
  always_comb begin
    bit_shifter_nxt = bit_shifter_r;
    bit_count_nxt   = bit_count_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_byte_nxt    = out_byte_r;
    out_last_nxt    = out_last_r;
    if (s1_advance && is_pixel) begin
      if (emit) begin
        bit_shifter_nxt = '0;
        bit_count_nxt   = '0;
        out_valid_nxt   = 1'b1;
        out_byte_nxt    = shift_full << pad;
        out_last_nxt    = s1_item.row_end;
      end else begin
        bit_shifter_nxt = shift_full;
        bit_count_nxt   = count_inc[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_shifter_r <= '0;
      bit_count_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      bit_shifter_r <= bit_shifter_nxt;
      bit_count_r   <= bit_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.packed_byte = out_byte_r;
  assign out_ch.row_last    = out_last_r;

endmodule

FILE: hw/rtl/pixel_to_mono_threshold_packer.sv
// Top level of the monochrome threshold packer.
// Takes a palette write (stored in the palette RAM) or one pixel that is turned into a gray
// level, thresholded at 128 and packed MSB first into a byte. A byte leaves after every eighth
// pixel, and at a row end the partial byte leaves zero-padded with row_last set. The edge that
// accepts an item reads the palette RAM and loads the stage register; gray, threshold and
// packing work from that stage, which loads a completed byte into the output register once
// that register holds no untaken byte. With the output side ready the block sustains one item
// per cycle; a palette write is visible to a pixel accepted in the next cycle. The palette is
// not cleared: an index must be written before a pixel reads it.
module pixel_to_mono_threshold_packer #(
  parameter int PALETTE_DEPTH = ptm_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ptm_in_if.sink                         in_ch,
  ptm_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ptm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ptm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ptm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import ptm_pkg::*;

  localparam int PAL_AW = $clog2(PALETTE_DEPTH);
  localparam logic [IDX_W:0] DEPTH_LIM = (IDX_W+1)'(PALETTE_DEPTH);

  pixel_fmt_t         pixel_format;
  logic               accept;
  logic               s1_advance;
  logic               s1_valid_r, s1_valid_nxt;
  s1_item_t           s1_item_r, s1_item_nxt;
  logic [IDX_W-1:0]   rd_idx;
  logic               rd_oob;
  logic               pal_we;
  logic               pal_re;
  logic [COLOR_W-1:0] pal_color;

  // Register block.
  ptm_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pixel_format (pixel_format)
  );

  assign in_ch.ready = !s1_valid_r || s1_advance;
  assign accept      = in_ch.valid && in_ch.ready;

  // Palette index of the pixel and whether it lies beyond the palette.
  assign rd_idx = (pixel_format == FMT_IDX4) ? {4'd0, in_ch.pixel_value[3:0]}
                                             : in_ch.pixel_value[7:0];
  assign rd_oob = ({1'b0, rd_idx} >= DEPTH_LIM);

  assign pal_we = accept && (in_ch.cmd == CMD_PAL_WRITE)
               && ({1'b0, in_ch.palette_index} < DEPTH_LIM);
  assign pal_re = accept && (in_ch.cmd == CMD_PIXEL);

  // Palette memory.
  ptm_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_ch.palette_index[PAL_AW-1:0]),
    .wdata (in_ch.palette_color),
    .re    (pal_re),
    .raddr (rd_idx[PAL_AW-1:0]),
    .rdata (pal_color)
  );

  // Stage that waits for the palette read data.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (accept) begin
      s1_valid_nxt            = 1'b1;
      s1_item_nxt.cmd         = in_ch.cmd;
      s1_item_nxt.fmt         = pixel_format;
      s1_item_nxt.pixel_value = in_ch.pixel_value;
      s1_item_nxt.row_end     = in_ch.row_end;
      s1_item_nxt.idx_oob     = rd_oob;
    end else if (s1_advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
  end

  // Gray, threshold, packing and output register.
  ptm_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid_r),
    .s1_item    (s1_item_r),
    .pal_color  (pal_color),
    .s1_advance (s1_advance),
    .out_ch     (out_ch)
  );

endmodule

FILE: hw/rtl/ptm_checker.sv
// Port-level checks of the monochrome threshold packer and their binding.
module ptm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_packed_byte,
  input logic       out_row_last
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before it was taken");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_packed_byte) && $stable(out_row_last))
    else $error("stalled result item changed");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A fresh result comes from an accepted item that passed through the stage register.
  a_rise_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without an item accepted two cycles before");

endmodule

bind pixel_to_mono_threshold_packer ptm_checker u_ptm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_packed_byte (out_ch.packed_byte),
  .out_row_last    (out_ch.row_last)
);

FILE: verif/pixel_to_mono_threshold_packer_test.sv
// Self-checking testbench of the monochrome threshold packer: directed and random pixel streams.
module pixel_to_mono_threshold_packer_test;
  import ptm_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 50;
  localparam logic [CFG_ADDR_W-1:0] FORMAT_ADDR   = {REG_PIXEL_FORMAT, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = {1'b1, 2'b00};

  typedef struct {
    logic        cmd;
    logic [23:0] pixel_value;
    logic        row_end;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
  } pixel_item_t;

  typedef struct {
    logic [7:0] packed_byte;
    logic       row_last;
  } mono_byte_t;

  typedef enum {RX_STALLS_HEAVY, TX_GAPS_HEAVY, NO_IDLE} idle_mode_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  ptm_in_if  in_ch ();
  ptm_out_if out_ch ();

  pixel_to_mono_threshold_packer DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Items waiting to be sent and packed bytes waiting to arrive.
  pixel_item_t pending_items[$];
  mono_byte_t  expected_bytes[$];

  // Own copy of the block's state, advanced on every accepted item.
  pixel_fmt_t  fmt_copy;
  logic [23:0] palette_copy[256];
  logic [7:0]  shift_copy;
  int          count_copy;

  // Palette entries that the generated stream has written so far.
  bit          palette_written[256];

  idle_mode_t  idle_mode;
  bit          in_taken;
  int          error_count;
  int          stall_cycles;
  mono_byte_t  want_byte;

  always #2 clk = ~clk;

  // Gray level of one pixel under the current format.
  function automatic int unsigned mono_gray_level(logic [23:0] pv);
    logic [23:0] color;
    int unsigned word;
    int unsigned lo;
    int unsigned hi;
    case (fmt_copy)
      FMT_IDX4: color = palette_copy[pv[3:0]];
      FMT_IDX8: color = palette_copy[pv[7:0]];
      FMT_RGB565: begin
        word = pv[15:0];
        lo = word & 'hff;
        hi = word >> 8;
        return ((hi & 'hf8) + ((word << 2) & 'h1f0) + ((lo << 3) & 'hf8)) / 4;
      end
      default: color = pv;
    endcase
    return (int'(color[7:0]) + 2 * int'(color[15:8]) + int'(color[23:16])) / 4;
  endfunction

  // Apply one accepted item and queue the packed byte it completes, if any.
  function automatic void pack_pixel_item(pixel_item_t it);
    int fill;
    mono_byte_t done_byte;
    if (it.cmd == CMD_PAL_WRITE) begin
      palette_copy[it.palette_index] = it.palette_color;
      return;
    end
    shift_copy = {shift_copy[6:0], mono_gray_level(it.pixel_value) >= WHITE_LEVEL};
    count_copy++;
    if (count_copy >= 8 || it.row_end) begin
      fill = 8 - count_copy;
      done_byte.packed_byte = shift_copy << fill;
      done_byte.row_last = it.row_end;
      expected_bytes.push_back(done_byte);
      shift_copy = '0;
      count_copy = 0;
    end
  endfunction

  task automatic push_palette(logic [7:0] idx, logic [23:0] color);
    pixel_item_t it;
    it.cmd = CMD_PAL_WRITE;
    it.pixel_value = 24'($urandom);
    it.row_end = 1'($urandom);
    it.palette_index = idx;
    it.palette_color = color;
    palette_written[idx] = 1'b1;
    pending_items.push_back(it);
  endtask

  task automatic push_pixel(logic [23:0] pv, logic row_end);
    pixel_item_t it;
    it.cmd = CMD_PIXEL;
    it.pixel_value = pv;
    it.row_end = row_end;
    it.palette_index = 8'($urandom);
    it.palette_color = 24'($urandom);
    pending_items.push_back(it);
  endtask

  // One APB transfer: setup cycle, access cycle, then release.
  task automatic apb_transfer(logic wr, logic [CFG_ADDR_W-1:0] addr, logic [31:0] data,
                              output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the format register with random upper bits and read it back.
  task automatic set_format(pixel_fmt_t fmt);
    logic [31:0] rdata;
    apb_transfer(1'b1, FORMAT_ADDR, {30'($urandom), fmt}, rdata);
    fmt_copy = fmt;
    apb_transfer(1'b0, FORMAT_ADDR, 32'($urandom), rdata);
    if (rdata !== 32'(fmt)) begin
      $error("pixel_format: expected %0d, got %0d", fmt, rdata);
      error_count++;
    end
  endtask

  // Let every queued item go through and the pipeline empty.
  task automatic drain();
    while (pending_items.size() != 0 || expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender and receiver: change inputs at the falling edge, hold an item until taken.
  always @(negedge clk) begin
    if (rst_n && in_ch.valid && !in_taken) begin
      // Item still offered; keep it.
    end else if (rst_n && pending_items.size() != 0 &&
                 $urandom_range(99) >= (idle_mode == RX_STALLS_HEAVY ? 8 :
                                        idle_mode == TX_GAPS_HEAVY ? 72 : 0)) begin
      in_ch.valid <= 1'b1;
      in_ch.cmd <= pending_items[0].cmd;
      in_ch.pixel_value <= pending_items[0].pixel_value;
      in_ch.row_end <= pending_items[0].row_end;
      in_ch.palette_index <= pending_items[0].palette_index;
      in_ch.palette_color <= pending_items[0].palette_color;
    end else begin
      in_ch.valid <= 1'b0;
    end
    if (rst_n) begin
      out_ch.ready <= $urandom_range(99) >= (idle_mode == RX_STALLS_HEAVY ? 72 :
                                             idle_mode == TX_GAPS_HEAVY ? 8 : 0);
    end
  end

  // Monitor: predict on accepted inputs, check accepted bytes, watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken = in_ch.valid && in_ch.ready;
      if (in_taken) begin
        pack_pixel_item(pending_items.pop_front());
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("packed_byte: expected nothing, got %02h", out_ch.packed_byte);
          error_count++;
        end else begin
          want_byte = expected_bytes.pop_front();
          if (out_ch.packed_byte !== want_byte.packed_byte) begin
            $error("packed_byte: expected %02h, got %02h", want_byte.packed_byte,
                   out_ch.packed_byte);
            error_count++;
          end
          if (out_ch.row_last !== want_byte.row_last) begin
            $error("row_last: expected %0d, got %0d", want_byte.row_last, out_ch.row_last);
            error_count++;
          end
        end
      end
      if (in_taken || (out_ch.valid && out_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles == STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] rdata;
    int queued;
    int row_len;
    logic [7:0] idx;
    logic [23:0] pv;
    pixel_fmt_t gen_fmt;

    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_PIXEL;
    in_ch.pixel_value = '0;
    in_ch.row_end = 1'b0;
    in_ch.palette_index = '0;
    in_ch.palette_color = '0;
    out_ch.ready = 1'b0;
    in_taken = 1'b0;
    error_count = 0;
    stall_cycles = 0;
    idle_mode = NO_IDLE;
    fmt_copy = FMT_RESET;
    shift_copy = '0;
    count_copy = 0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Palette extremes and entries just around the white threshold.
    push_palette(8'd0, 24'h000000);
    push_palette(8'd255, 24'hffffff);
    push_palette(8'd15, 24'h808080);
    push_palette(8'd1, 24'h7f807f);

    // Direct color after reset: a full byte that ends a row, then a short row.
    push_pixel(24'h000000, 1'b0);
    push_pixel(24'hffffff, 1'b0);
    push_pixel(24'h808080, 1'b0);
    push_pixel(24'h80807f, 1'b0);
    push_pixel(24'h7f7f7f, 1'b0);
    push_pixel(24'h00ff02, 1'b0);
    push_pixel(24'hff00ff, 1'b0);
    push_pixel(24'hffffff, 1'b1);
    push_pixel(24'h00ff01, 1'b0);
    push_pixel(24'h808080, 1'b0);
    push_pixel(24'h00ff00, 1'b1);
    drain();

    // A write to an address past the register list must change nothing.
    apb_transfer(1'b1, UNMAPPED_ADDR, 32'($urandom), rdata);

    // Indexed and RGB565 pixels, with the format changing in the middle of a row.
    set_format(FMT_IDX4);
    push_pixel(24'hfffff0, 1'b0);
    push_pixel(24'h00000f, 1'b0);
    drain();
    set_format(FMT_IDX8);
    push_pixel(24'hffff01, 1'b0);
    push_pixel(24'h0000ff, 1'b0);
    drain();
    set_format(FMT_RGB565);
    push_pixel(24'hffffff, 1'b0);
    push_pixel(24'h000000, 1'b0);
    push_pixel(24'hff0000, 1'b1);
    drain();

    // Random rows under every format and every idling pattern.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_mode = idle_mode_t'(p / 4);
      gen_fmt = pixel_fmt_t'(2'((p + p / 4) % 4));
      set_format(gen_fmt);
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        row_len = ($urandom_range(3) == 0) ? 8 * $urandom_range(1, 2) : $urandom_range(1, 20);
        for (int k = 0; k < row_len; k++) begin
          if ($urandom_range(9) == 0) begin
            push_palette(8'($urandom), 24'($urandom));
            queued++;
          end
          pv = 24'($urandom);
          if (gen_fmt == FMT_IDX4 || gen_fmt == FMT_IDX8) begin
            idx = (gen_fmt == FMT_IDX4) ? 8'($urandom_range(15)) : 8'($urandom);
            // An index is always written before a pixel reads it.
            if (!palette_written[idx]) begin
              push_palette(idx, 24'($urandom));
              queued++;
            end
            if (gen_fmt == FMT_IDX4) pv[3:0] = idx[3:0];
            else pv[7:0] = idx;
          end
          push_pixel(pv, k == row_len - 1);
          queued++;
        end
      end
      drain();
    end

    if (expected_bytes.size() != 0) begin
      $error("packed_byte: %0d expected item(s) never arrived", expected_bytes.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ptm_pkg.sv
hw/rtl/ptm_if.sv
hw/rtl/ptm_ram.sv
hw/rtl/ptm_cfg.sv
hw/rtl/ptm_pack.sv
hw/rtl/pixel_to_mono_threshold_packer.sv
hw/rtl/ptm_checker.sv
verif/pixel_to_mono_threshold_packer_test.sv
